// File: design/cars_pkg.sv
`default_nettype none
package cars_pkg;
  localparam int MaxChannelsDefault = 1024;
  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeRelu  = 2'd1;
  localparam logic [1:0] ModeScale = 2'd2;
  localparam logic [1:0] RegOpMode  = 2'd0;
  localparam logic [1:0] RegChans   = 2'd1;
  localparam logic [1:0] RegStride  = 2'd2;
  localparam logic [1:0] RegBatches = 2'd3;
  localparam logic [31:0] CanonNan = 32'h7FC00000;

  // fp32 multiply, round to nearest even, full subnormal support
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic sa, sb, sr;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [11:0] e;
    logic [49:0] w;
    logic [5:0] lz;
    logic [25:0] keep;
    logic stk, rb, inc;
    logic [24:0] m;
    logic signed [11:0] sh;
    begin
      sa = a[31]; sb = b[31]; sr = sa ^ sb;
      ea = a[30:23]; eb = b[30:23];
      ma = {ea != 8'd0, a[22:0]}; mb = {eb != 8'd0, b[22:0]};
      fmul = 32'd0;
      if ((ea == 8'hFF && a[22:0] != 23'd0) || (eb == 8'hFF && b[22:0] != 23'd0)) begin
        fmul = CanonNan;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
        if ((ea == 8'd0 && a[22:0] == 23'd0) || (eb == 8'd0 && b[22:0] == 23'd0))
          fmul = CanonNan;
        else fmul = {sr, 8'hFF, 23'd0};
      end else begin
        p = ma * mb;
        if (p == 48'd0) begin
          fmul = {sr, 31'd0};
        end else begin
          // value = p * 2^(e-1-23-23), normalize so bit 47 is leading
          lz = 6'd0;
          for (int i = 0; i < 48; i++) if (p[i]) lz = 6'(47 - i);
          p = p << lz;
          e = 12'(signed'({4'd0, (ea == 8'd0) ? 8'd1 : ea}))
            + 12'(signed'({4'd0, (eb == 8'd0) ? 8'd1 : eb})) - 12'sd126 - 12'(lz);
          w = {p, 2'b00};
          if (e < 12'sd1) begin
            sh = 12'sd1 - e;
            if (sh > 12'sd49) begin
              stk = |w; w = 50'd0;
            end else begin
              stk = 1'b0;
              for (int i = 0; i < 50; i++) if (i < sh && w[i]) stk = 1'b1;
              w = w >> sh;
            end
            w[0] = w[0] | stk;
            e = 12'sd0;
          end
          keep = w[49:24];
          rb = keep[1];
          stk = keep[0] | (|w[23:0]);
          inc = rb & (stk | keep[2]);
          m = {1'b0, keep[25:2]} + 25'(inc);
          if (m[24]) begin m = m >> 1; e = e + 12'sd1; end
          if (e == 12'sd0 && m[23]) e = 12'sd1;
          if (e >= 12'sd255) fmul = {sr, 8'hFF, 23'd0};
          else fmul = {sr, e[7:0], m[22:0]};
        end
      end
    end
  endfunction

  // fp32 add, round to nearest even
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] ea, eb, el;
    logic [26:0] ma, mb, t;
    logic [27:0] s;
    logic sa, sb, sl, stk;
    logic [7:0] d;
    logic [4:0] lz;
    logic signed [9:0] e;
    logic [24:0] m;
    logic [31:0] hi, lo;
    logic rb, inc;
    begin
      fadd = 32'd0;
      if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0)) begin
        fadd = CanonNan;
      end else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) begin
        fadd = (a[31] == b[31]) ? a : CanonNan;
      end else if (a[30:23] == 8'hFF) begin
        fadd = a;
      end else if (b[30:23] == 8'hFF) begin
        fadd = b;
      end else begin
        if (a[30:0] >= b[30:0]) begin hi = a; lo = b; end else begin hi = b; lo = a; end
        sa = hi[31]; sb = lo[31];
        ea = hi[30:23]; eb = lo[30:23];
        ma = {ea != 0, hi[22:0], 3'b000};
        mb = {eb != 0, lo[22:0], 3'b000};
        el = (ea == 0) ? 8'd1 : ea;
        d = el - ((eb == 0) ? 8'd1 : eb);
        if (d > 8'd26) begin
          stk = |mb; mb = 27'd0;
        end else begin
          t = mb >> d; stk = (t << d) != mb; mb = t;
        end
        mb[0] = mb[0] | stk;
        if (sa == sb) s = {1'b0, ma} + {1'b0, mb};
        else s = {1'b0, ma} - {1'b0, mb};
        sl = sa;
        e = 10'(el);
        if (s == 28'd0) begin
          fadd = {sa & sb, 31'd0};
        end else begin
          if (s[27]) begin
            s = {1'b0, s[27:2], s[1] | s[0]}; e = e + 10'sd1;
          end else begin
            lz = 5'd0;
            for (int i = 0; i < 27; i++) if (s[i]) lz = 5'(26 - i);
            if (10'(lz) > e - 10'sd1) lz = 5'(e - 10'sd1);
            s = s << lz; e = e - 10'(lz);
            if (!s[26]) e = 10'sd0;
          end
          rb = s[2]; inc = rb & (s[1] | s[0] | s[3]);
          m = {1'b0, s[26:3]} + 25'(inc);
          if (m[24]) begin m = m >> 1; e = e + 10'sd1; end
          if (e == 10'sd0 && m[23]) e = 10'sd1;
          if (e >= 10'sd255) fadd = {sl, 8'hFF, 23'd0};
          else fadd = {sl, e[7:0], m[22:0]};
        end
      end
    end
  endfunction
endpackage
`default_nettype wire

// File: design/channel_affine_relu_stream.sv
`default_nettype none
// Per-channel affine + optional ReLU on an fp32 stream, one element per cycle
// while the output is not stalled. Coefficients sit in two synchronous RAMs
// indexed by channel; stage 1 reads them, stage 2 multiplies in scale mode,
// stage 3 adds, stage 4 is the output register. A stall holds the whole pipe.
// A write transfer (tuser=1) loads one channel, produces no output and applies
// to every element accepted after it.
module channel_affine_relu_stream #(
  parameter int MAX_CHANNELS = cars_pkg::MaxChannelsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [111:0] s_tdata, // coef_channel, coef_scale, coef_bias, sample, 6'b0
  input  wire logic        s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // result
  output logic             m_tlast   // last
);
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [1:0]  op_mode;
  logic [10:0] channel_count;
  logic [24:0] plane_size;
  logic [15:0] batch_count;
  logic [23:0] element_counter;
  logic [9:0]  channel_index;
  logic [15:0] batch_index;

  logic [31:0] scale_mem [MAX_CHANNELS];
  logic [31:0] bias_mem  [MAX_CHANNELS];

  logic v1, v2, v3, v4;
  logic [31:0] x1, b2, s_rd, b_rd, sum3;
  logic [31:0] p2;
  logic [1:0]  m2;
  logic last1, last2, last3, last4;
  logic [31:0] res4;

  wire adv = !v4 || m_tready;
  assign s_tready = adv;
  wire acc = s_tvalid && s_tready;
  wire wr  = acc && s_tuser;
  wire dat = acc && !s_tuser;
  wire [9:0]  wch = s_tdata[9:0];
  wire [31:0] wsc = s_tdata[41:10];
  wire [31:0] wbi = s_tdata[73:42];
  wire [31:0] smp = s_tdata[105:74];

  logic [24:0] stride_e;
  logic [10:0] chans_e;
  logic [15:0] batches_e;
  always_comb begin
    stride_e = (plane_size == 25'd0) ? 25'd1 :
               (plane_size > 25'd16777216) ? 25'd16777216 : plane_size;
    chans_e = (channel_count == 11'd0) ? 11'd1 :
              (32'(channel_count) > MAX_CHANNELS) ? 11'(MAX_CHANNELS) : channel_count;
    batches_e = (batch_count == 16'd0) ? 16'd1 : batch_count;
  end
  wire end_chan  = 25'(element_counter) + 25'd1 >= stride_e;
  wire end_batch = end_chan && (11'(channel_index) + 11'd1 >= chans_e);
  wire end_all   = end_batch && (17'(batch_index) + 17'd1 >= 17'(batches_e));
  wire [AW-1:0] sel = (32'(channel_index) >= MAX_CHANNELS) ? '0 : AW'(channel_index);

  // coefficient RAMs; a write lands before the next element's read
  always_ff @(posedge clk) begin
    if (wr && 32'(wch) < MAX_CHANNELS) begin
      scale_mem[AW'(wch)] <= wsc;
      bias_mem[AW'(wch)]  <= wbi;
    end
    if (adv) begin
      s_rd <= scale_mem[sel];
      b_rd <= bias_mem[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= cars_pkg::ModeAdd;
      channel_count <= 11'd1;
      plane_size <= 25'd1;
      batch_count <= 16'd1;
      element_counter <= '0;
      channel_index <= '0;
      batch_index <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cars_pkg::RegOpMode:  op_mode <= cfg_data[1:0];
          cars_pkg::RegChans:   channel_count <= cfg_data[10:0];
          cars_pkg::RegStride:  plane_size <= cfg_data;
          cars_pkg::RegBatches: batch_count <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (dat) begin
        if (!end_chan) element_counter <= element_counter + 24'd1;
        else begin
          element_counter <= '0;
          if (!end_batch) channel_index <= channel_index + 10'd1;
          else begin
            channel_index <= '0;
            batch_index <= end_all ? 16'd0 : batch_index + 16'd1;
          end
        end
      end
      if (adv) begin
        v1 <= dat; v2 <= v1; v3 <= v2; v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dat) begin x1 <= smp; last1 <= end_all; end
      b2 <= b_rd; m2 <= op_mode; last2 <= last1;
      p2 <= (op_mode == cars_pkg::ModeScale) ? cars_pkg::fmul(s_rd, x1) : x1;
      sum3 <= cars_pkg::fadd(p2, b2);
      last3 <= last2;
      if (m2 == cars_pkg::ModeRelu)
        res4 <= (!sum3[31] && sum3[30:0] != 31'd0 &&
                 !(sum3[30:23] == 8'hFF && sum3[22:0] != 23'd0)) ? sum3 : 32'd0;
      else res4 <= sum3;
      last4 <= last3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = res4;
  assign m_tlast  = last4;
endmodule
`default_nettype wire
